@@ rtl/core/jtv_pkg.sv @@
// ----------------------------------------------------------------------------
// jtv_pkg : shared types and constants for the joystick velocity mapper
// Event kinds, button and axis numbers, limits and the inter-stage words.
// ----------------------------------------------------------------------------
package jtv_pkg;

    // event kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_AXIS      = 2'd0,
        KIND_BUTTON    = 2'd1,
        KIND_TICK      = 2'd2,
        KIND_RECONNECT = 2'd3
    } kind_t;

    // axis and button numbers that the block reacts to
    localparam logic [7:0] AXIS_FORWARD   = 8'd1;
    localparam logic [7:0] AXIS_TURN      = 8'd3;
    localparam logic [7:0] BTN_DEADMAN    = 8'd4;
    localparam logic [7:0] BTN_LIMIT_UP   = 8'd5;
    localparam logic [7:0] BTN_LIMIT_DOWN = 8'd7;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_LIMIT = 8'd1;

    // limits in thousandths, deadband in raw axis units
    localparam logic [10:0] LIMIT_STEP       = 11'd100;
    localparam logic [10:0] LIMIT_MAX        = 11'd2000;
    localparam logic [10:0] LIMIT_DEFAULT    = 11'd500;
    localparam logic [10:0] TURN_DEFAULT     = 11'd280;
    localparam logic [14:0] DEADBAND_DEFAULT = 15'd3000;

    // full scale is 2^15 - 1
    localparam int FULL_SCALE_SHIFT = 15;
    localparam int PROD_W           = 28;   // 17-bit magnitude x 11-bit limit

    // one joystick event
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         number;
        logic signed [15:0] value;
    } event_t;

    // one axis ready for the constant divide
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic              zero;
    } scale_op_t;

    // product stage word
    typedef struct packed {
        scale_op_t lin;
        scale_op_t ang;
        logic      active;
    } prod_word_t;

endpackage

@@ rtl/core/jtv_input.sv @@
// ----------------------------------------------------------------------------
// jtv_input : input register
// Holds one accepted event word until the state stage takes it.
// ----------------------------------------------------------------------------
module jtv_input import jtv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // number[7:0], value[23:8]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    input  logic        pop,
    output logic        ev_valid,
    output event_t      ev
);

    logic   valid_reg, valid_next;
    event_t ev_reg;

    assign s_tready = !valid_reg || pop;

    // valid flag
    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ev_reg.kind   <= kind_t'(s_tuser);
            ev_reg.number <= s_tdata[7:0];
            ev_reg.value  <= s_tdata[23:8];
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

@@ rtl/core/jtv_state.sv @@
// ----------------------------------------------------------------------------
// jtv_state : event state and product stage
// Applies an event to the axes, deadman and limits, and registers the
// axis-times-limit products for events that give a command word.
// ----------------------------------------------------------------------------
module jtv_state import jtv_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ev_valid,
    input  event_t                 ev,
    output logic                   ev_pop,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   pw_valid,
    output prod_word_t             pw,
    input  logic                   pw_pop
);

    logic signed [15:0] fwd_reg, fwd_next;
    logic signed [15:0] turn_reg, turn_next;
    logic               deadman_reg, deadman_next;
    logic [10:0]        speed_reg, speed_next;
    logic [10:0]        turn_lim_reg, turn_lim_next;
    logic [14:0]        deadband_reg, deadband_next;
    logic               pw_valid_reg, pw_valid_next;
    prod_word_t         pw_reg;

    logic        emits;
    logic        live;
    logic        take;
    logic [11:0] speed_up;
    logic [16:0] fwd_mag, turn_mag;
    prod_word_t  pw_calc;

    // does this event give a command word
    always_comb begin
        emits = 1'b0;
        live  = 1'b1;
        case (ev.kind)
            KIND_AXIS: begin
                emits = (ev.number == AXIS_FORWARD) || (ev.number == AXIS_TURN);
            end
            KIND_TICK: begin
                emits = 1'b1;
                live  = deadman_reg;
            end
            default: begin
                emits = 1'b0;
            end
        endcase
    end

    // non-emitting events never wait on the product register
    assign take   = ev_valid && (!emits || !pw_valid_reg || pw_pop);
    assign ev_pop = take;

    assign speed_up = {1'b0, speed_reg} + {1'b0, LIMIT_STEP};

    // next state
    always_comb begin
        fwd_next      = fwd_reg;
        turn_next     = turn_reg;
        deadman_next  = deadman_reg;
        speed_next    = speed_reg;
        turn_lim_next = turn_lim_reg;
        deadband_next = deadband_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_DEADBAND) begin
                deadband_next = cfg_data;
            end else if (cfg_index == CFG_TURN_LIMIT) begin
                turn_lim_next = cfg_data[10:0];
            end
        end
        if (take) begin
            case (ev.kind)
                KIND_AXIS: begin
                    if (ev.number == AXIS_FORWARD) begin
                        fwd_next = ev.value;
                    end else if (ev.number == AXIS_TURN) begin
                        turn_next = ev.value;
                    end
                end
                KIND_BUTTON: begin
                    if (ev.number == BTN_DEADMAN) begin
                        deadman_next = (ev.value == 16'sd1);
                    end else if (ev.number == BTN_LIMIT_UP && ev.value == 16'sd1) begin
                        speed_next = (speed_up > {1'b0, LIMIT_MAX}) ? LIMIT_MAX
                                                                    : speed_up[10:0];
                    end else if (ev.number == BTN_LIMIT_DOWN && ev.value == 16'sd1) begin
                        speed_next = (speed_reg < LIMIT_STEP) ? 11'd0
                                                              : speed_reg - LIMIT_STEP;
                    end
                end
                KIND_RECONNECT: begin
                    speed_next    = LIMIT_DEFAULT;
                    turn_lim_next = TURN_DEFAULT;
                end
                default: begin
                end
            endcase
        end
    end

    // magnitudes of the updated axes (the negated axis has the same size)
    assign fwd_mag  = fwd_next[15]  ? 17'(-{fwd_next[15], fwd_next})
                                    : {1'b0, fwd_next};
    assign turn_mag = turn_next[15] ? 17'(-{turn_next[15], turn_next})
                                    : {1'b0, turn_next};

    // products, signs and deadband decisions
    always_comb begin
        pw_calc.lin.prod = {11'd0, fwd_mag} * {17'd0, speed_reg};
        pw_calc.lin.neg  = !fwd_next[15];
        pw_calc.lin.zero = !live || (fwd_mag < {2'b00, deadband_reg});
        pw_calc.ang.prod = {11'd0, turn_mag} * {17'd0, turn_lim_reg};
        pw_calc.ang.neg  = !turn_next[15];
        pw_calc.ang.zero = !live || (turn_mag < {2'b00, deadband_reg});
        pw_calc.active   = deadman_reg;
    end

    always_comb begin
        pw_valid_next = pw_valid_reg;
        if (take && emits) begin
            pw_valid_next = 1'b1;
        end else if (pw_pop) begin
            pw_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg      <= '0;
            turn_reg     <= '0;
            deadman_reg  <= 1'b0;
            speed_reg    <= LIMIT_DEFAULT;
            turn_lim_reg <= TURN_DEFAULT;
            deadband_reg <= DEADBAND_DEFAULT;
            pw_valid_reg <= 1'b0;
        end else begin
            fwd_reg      <= fwd_next;
            turn_reg     <= turn_next;
            deadman_reg  <= deadman_next;
            speed_reg    <= speed_next;
            turn_lim_reg <= turn_lim_next;
            deadband_reg <= deadband_next;
            pw_valid_reg <= pw_valid_next;
        end
    end

    // product word, no reset
    always_ff @(posedge aclk) begin
        if (take && emits) begin
            pw_reg <= pw_calc;
        end
    end

    assign pw_valid = pw_valid_reg;
    assign pw       = pw_reg;

endmodule

@@ rtl/core/jtv_output.sv @@
// ----------------------------------------------------------------------------
// jtv_output : divide by full scale and output register
// Divides each product by 2^15-1 with a shift-add, applies sign and
// deadband, and holds the command word for the master side.
// ----------------------------------------------------------------------------
module jtv_output import jtv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pw_valid,
    input  prod_word_t  pw,
    output logic        pw_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // linear_milli[11:0], angular_milli[23:12]
    output logic [0:0]  m_tuser     // control_active[0]
);

    // floor(p / (2^15-1)) = (p + (p >> 15) + 1) >> 15 while the quotient
    // stays below 2^15, which holds for these products
    function automatic logic [11:0] scale(input scale_op_t op);
        logic [PROD_W:0] sum;
        logic [11:0]     q;
        sum = {1'b0, op.prod} + (PROD_W+1)'(op.prod >> FULL_SCALE_SHIFT)
              + (PROD_W+1)'(1);
        q   = {1'b0, sum[FULL_SCALE_SHIFT+10:FULL_SCALE_SHIFT]};
        if (op.zero) begin
            return 12'd0;
        end
        return op.neg ? 12'(-q) : q;
    endfunction

    logic        valid_reg, valid_next;
    logic [23:0] data_reg;
    logic        user_reg;
    logic        load;

    assign pw_pop = !valid_reg || m_tready;
    assign load   = pw_valid && pw_pop;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result word, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {scale(pw.ang), scale(pw.lin)};
            user_reg <= pw.active;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

@@ rtl/core/joystick_teleop_velocity_mapper_top.sv @@
// ----------------------------------------------------------------------------
// joystick_teleop_velocity_mapper_top : joystick events to velocity words
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    tdata number,value  tuser kind
//   m_       out  m_tvalid/m_tready    tdata linear,angular tuser control_active
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One event word a cycle while m_ takes its words; three registers (input,
// product, output) lie between acceptance and a result word on m_.
// The product register holds one multiply per axis; the divide by full scale
// is a shift-add in front of the output register.
// Synchronous active-low reset restores the axes, deadman and limits.
// A stalled m_ side backs up into s_tready; events that give no word pass on.
// ----------------------------------------------------------------------------
module joystick_teleop_velocity_mapper_top import jtv_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,    // number[7:0], value[23:8]
    input  logic [1:0]             s_tuser,    // kind[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,    // linear_milli[11:0], angular_milli[23:12]
    output logic [0:0]             m_tuser,    // control_active[0]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic       ev_valid;
    event_t     ev;
    logic       ev_pop;
    logic       pw_valid;
    prod_word_t pw;
    logic       pw_pop;

    assign cfg_ready = 1'b1;

    jtv_input u_input (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (ev_pop),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    jtv_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ev_valid  (ev_valid),
        .ev        (ev),
        .ev_pop    (ev_pop),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pw_valid  (pw_valid),
        .pw        (pw),
        .pw_pop    (pw_pop)
    );

    jtv_output u_output (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pw_valid (pw_valid),
        .pw       (pw),
        .pw_pop   (pw_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // the input only stalls while it holds a word
    a_stall_holds_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> ev_valid)
        else $error("s_tready low with empty input register");

    // a product word moved on shows up as a result word
    a_product_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (pw_valid && pw_pop) |=> m_tvalid)
        else $error("product word lost on its way to the output");

    // a blocked output keeps the pending product word
    a_product_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && pw_valid) |=> pw_valid)
        else $error("product word dropped while output stalled");
`endif

endmodule
